// ===== rtl/manchester_frame_sync_crc_receiver_defines.svh =====
// Assertion macros for the Manchester frame receiver.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MANCHESTER_FRAME_SYNC_CRC_RECEIVER_DEFINES_SVH
`define MANCHESTER_FRAME_SYNC_CRC_RECEIVER_DEFINES_SVH

// same-cycle implication
`define MFR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mfr_pkg.sv =====
// Package for the Manchester frame receiver: constants and CRC-8 helper.
// No dependencies.
`timescale 1ns / 1ps
package mfr_pkg;
   localparam int SAMPLES_PER_BIT  = 8;
   localparam int SYNC_SAMPLES     = 192;
   localparam int SYNC_BITS        = 24;
   localparam int DEF_MAX_PAYLOAD  = 31;
   localparam int DEF_STORE_DEPTH  = 4096;
   localparam logic [23:0] SYNC_NORMAL  = 24'hf4cfb3;
   localparam logic [23:0] SYNC_INVERSE = 24'h0b304c;
   localparam logic [4:0]  PAYLOAD_RESET = 5'd8;
   localparam logic [1:0]  PHASE_NORMAL  = 2'd0;
   localparam logic [1:0]  PHASE_INVERSE = 2'd1;
   localparam logic [1:0]  PHASE_UNDEF   = 2'd2;

   // Dallas/Maxim CRC-8, reflected poly 0x8c, one byte
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      c = crc ^ d;
      for (int j = 0; j < 8; j++) begin
         c = c[0] ? ((c >> 1) ^ 8'h8c) : (c >> 1);
      end
      return c;
   endfunction
endpackage

// ===== rtl/manchester_frame_sync_crc_receiver.sv =====
// Manchester frame receiver: sample store, sync search, byte slicer, CRC-8 check.
// Depends on mfr_pkg and manchester_frame_sync_crc_receiver_defines.svh.
//
// Usage: samples stream in on req_* one beat per cycle (tdata[11:0] = sample);
// req_tlast marks the last sample of a frame and starts decode. While decoding
// and emitting, req_tready is low. Results leave on rsp_* one beat per byte,
// payload first and CRC byte last (rsp_tlast on it).
// Decode runs on one shared accumulator, one store read at a time: sync search
// first, then nb+1 bytes, nb = payload_bytes saturated at MAX_PAYLOAD.
// Emission is one beat per cycle when rsp_tready is high; a stalled receiver
// holds the current beat and the block waits. After the last result beat the
// store reads as zero again (fill-count tracking, no clearing pass).
// Reset: store empty (reads zero), payload_bytes = 8, idle and ready.
// csr_we writes payload_bytes; write only while idle.
`timescale 1ns / 1ps
`include "manchester_frame_sync_crc_receiver_defines.svh"
module manchester_frame_sync_crc_receiver #(
   parameter int MAX_PAYLOAD = mfr_pkg::DEF_MAX_PAYLOAD,
   parameter int STORE_DEPTH = mfr_pkg::DEF_STORE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // sample[11:0], zero fill
   input  logic        req_tlast,  // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // data_byte[7:0], byte_index[12:8], phase[14:13],
                                   // bit_offset[17:15], crc_ok[18], zero fill
   output logic        rsp_tlast,  // last_byte
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);
   localparam int AW    = $clog2(STORE_DEPTH);
   // wide enough for the farthest decode read and for STORE_DEPTH itself
   localparam int RD_NEED = $clog2(7 + mfr_pkg::SYNC_SAMPLES
                                   + (MAX_PAYLOAD + 1) * 8 * mfr_pkg::SAMPLES_PER_BIT + 1);
   localparam int RD_W  = (RD_NEED > AW) ? RD_NEED : AW + 1;
   localparam int IDX_W = (MAX_PAYLOAD < 1) ? 1 : $clog2(MAX_PAYLOAD + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_BIT   = 3'd3;
   localparam logic [2:0] ST_OFFS  = 3'd4;
   localparam logic [2:0] ST_BSTRT = 3'd5;
   localparam logic [2:0] ST_BYTE  = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [11:0] store [STORE_DEPTH];
   logic [11:0] rd_data_ff;
   logic        rd_ok_ff;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic             wrap_ff, wrap_in;
   logic [4:0]       payload_ff;
   logic [RD_W-1:0]  addr_ff, addr_in;
   logic [2:0]       samp_ff, samp_in;
   logic [4:0]       bit_ff, bit_in;
   logic [2:0]       off_ff, off_in;
   logic             bytes_ff, bytes_in;
   logic [IDX_W-1:0] idx_ff, idx_in, nb_ff, nb_in;
   logic signed [15:0] k_ff, k_in;
   logic signed [20:0] cor_ff, cor_in;
   logic [23:0]      w_ff, w_in, best_w_ff, best_w_in;
   logic [19:0]      best_mag_ff, best_mag_in;
   logic [2:0]       best_off_ff, best_off_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       v_ff, v_in, crc_ff, crc_in;
   logic             crc_ok_ff, crc_ok_in;
   logic [7:0]       bbuf_ff [MAX_PAYLOAD + 1];
   logic             buf_we;
   logic [7:0]       byte_val;
   logic signed [15:0] sval;
   logic signed [20:0] cor_neg;
   logic [19:0]      mag;
   logic             rd_ok;

   wire req_acc = req_tvalid && req_tready;
   wire rsp_acc = rsp_tvalid && rsp_tready;

   // store: one write port for loading, one registered read port for decode
   always_ff @(posedge clock) begin
      if (req_acc) begin
         store[wp_ff] <= req_tdata[11:0];
      end
      rd_data_ff <= store[addr_ff[AW-1:0]];
      rd_ok_ff   <= rd_ok;
   end

   always_comb begin
      rd_ok = (addr_ff < RD_W'(STORE_DEPTH))
              && (wrap_ff || (addr_ff < RD_W'(wp_ff)));
   end

   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      wrap_in     = wrap_ff;
      addr_in     = addr_ff;
      samp_in     = samp_ff;
      bit_in      = bit_ff;
      off_in      = off_ff;
      bytes_in    = bytes_ff;
      idx_in      = idx_ff;
      nb_in       = nb_ff;
      k_in        = k_ff;
      cor_in      = cor_ff;
      w_in        = w_ff;
      best_w_in   = best_w_ff;
      best_mag_in = best_mag_ff;
      best_off_in = best_off_ff;
      phase_in    = phase_ff;
      v_in        = v_ff;
      crc_in      = crc_ff;
      crc_ok_in   = crc_ok_ff;
      buf_we      = 1'b0;
      sval        = rd_ok_ff ? $signed({4'd0, rd_data_ff}) : 16'sd0;
      cor_neg     = -cor_ff;
      mag         = cor_ff[20] ? cor_neg[19:0] : cor_ff[19:0];
      byte_val    = (phase_ff == mfr_pkg::PHASE_INVERSE) ? ~v_ff : v_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (wp_ff == AW'(STORE_DEPTH - 1)) begin
                  wp_in   = '0;
                  wrap_in = 1'b1;
               end else begin
                  wp_in = wp_ff + 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_ISSUE;
                  addr_in  = '0;
                  samp_in  = '0;
                  bit_in   = '0;
                  off_in   = '0;
                  bytes_in = 1'b0;
                  nb_in    = IDX_W'((int'(payload_ff) > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                                    : int'(payload_ff));
               end
            end
         end
         ST_ISSUE: state_in = ST_ACC;
         ST_ACC: begin
            // first half adds, second half subtracts
            if (samp_ff[2] == 1'b0) begin
               k_in = ((samp_ff == 3'd0) ? 16'sd0 : k_ff) + sval;
            end else begin
               k_in = k_ff - sval;
            end
            addr_in  = addr_ff + 1'b1;
            samp_in  = samp_ff + 1'b1;
            state_in = (samp_ff == 3'd7) ? ST_BIT : ST_ISSUE;
         end
         ST_BIT: begin
            bit_in   = bit_ff + 1'b1;
            state_in = ST_ISSUE;
            if (!bytes_ff) begin
               w_in = {(k_ff > 16'sd0), w_ff[23:1]};
               if (mfr_pkg::SYNC_NORMAL[bit_ff])
                  cor_in = ((bit_ff == 5'd0) ? 21'sd0 : cor_ff) + 21'(k_ff);
               else
                  cor_in = ((bit_ff == 5'd0) ? 21'sd0 : cor_ff) - 21'(k_ff);
               if (bit_ff == 5'(mfr_pkg::SYNC_BITS - 1)) state_in = ST_OFFS;
            end else begin
               v_in = {(k_ff > 16'sd0), v_ff[7:1]};
               if (bit_ff == 5'd7) state_in = ST_BYTE;
            end
         end
         ST_OFFS: begin
            if (off_ff == 3'd0 || mag > best_mag_ff) begin
               best_mag_in = mag;
               best_off_in = off_ff;
               best_w_in   = w_ff;
            end
            bit_in = '0;
            if (off_ff == 3'd7) begin
               state_in = ST_BSTRT;
            end else begin
               off_in   = off_ff + 1'b1;
               addr_in  = RD_W'(off_ff) + 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_BSTRT: begin
            addr_in  = RD_W'(best_off_ff) + RD_W'(mfr_pkg::SYNC_SAMPLES);
            bytes_in = 1'b1;
            idx_in   = '0;
            crc_in   = '0;
            if (best_w_ff == mfr_pkg::SYNC_NORMAL)       phase_in = mfr_pkg::PHASE_NORMAL;
            else if (best_w_ff == mfr_pkg::SYNC_INVERSE) phase_in = mfr_pkg::PHASE_INVERSE;
            else                                         phase_in = mfr_pkg::PHASE_UNDEF;
            state_in = ST_ISSUE;
         end
         ST_BYTE: begin
            buf_we = 1'b1;
            bit_in = '0;
            if (idx_ff == nb_ff) begin
               crc_ok_in = (crc_ff == byte_val);
               idx_in    = '0;
               state_in  = ST_EMIT;
            end else begin
               crc_in   = mfr_pkg::crc8_step(crc_ff, byte_val);
               idx_in   = idx_ff + 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               if (idx_ff == nb_ff) begin
                  state_in = ST_IDLE;
                  wp_in    = '0;
                  wrap_in  = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= '0;
         wrap_ff    <= 1'b0;
         payload_ff <= mfr_pkg::PAYLOAD_RESET;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         wrap_ff  <= wrap_in;
         if (csr_we) payload_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      samp_ff     <= samp_in;
      bit_ff      <= bit_in;
      off_ff      <= off_in;
      bytes_ff    <= bytes_in;
      idx_ff      <= idx_in;
      nb_ff       <= nb_in;
      k_ff        <= k_in;
      cor_ff      <= cor_in;
      w_ff        <= w_in;
      best_w_ff   <= best_w_in;
      best_mag_ff <= best_mag_in;
      best_off_ff <= best_off_in;
      phase_ff    <= phase_in;
      v_ff        <= v_in;
      crc_ff      <= crc_in;
      crc_ok_ff   <= crc_ok_in;
      if (buf_we) bbuf_ff[idx_ff] <= byte_val;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tlast  = (idx_ff == nb_ff);
   assign rsp_tdata  = {5'd0, crc_ok_ff, best_off_ff, phase_ff, 5'(idx_ff), bbuf_ff[idx_ff]};

   `MFR_ASSERT_NOW(a_no_overlap, clock, reset, 1'b1, !(req_tready && rsp_tvalid),
      "input ready while results pending")
   `MFR_ASSERT_NEXT(a_busy_after_end, clock, reset, req_acc && req_tlast, !req_tready,
      "ready right after frame end")
   `MFR_ASSERT_NEXT(a_store_cleared, clock, reset, rsp_acc && rsp_tlast,
      (wp_ff == '0) && !wrap_ff && req_tready, "store not released after frame")
   `MFR_ASSERT_NOW(a_last_bound, clock, reset, rsp_tvalid, idx_ff <= nb_ff,
      "byte index past CRC byte")
endmodule
